@@ rtl/core/tise_pkg.sv @@
// ----------------------------------------------------------------------------
// Triangle isoline segments: shared types and constants
// Vertex, triangle and segment records, and the divider request and response.
// ----------------------------------------------------------------------------
package tise_pkg;

    // Span must reach step/1000 before any level is traced.
    localparam logic [9:0] SPAN_RATIO = 10'd1000;

    // Configuration register indexes.
    localparam logic [1:0] REG_STEP   = 2'd0;
    localparam logic [1:0] REG_ORIGIN = 2'd1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] v;
    } t_vtx;

    // Triangle with vertices sorted by ascending value.
    typedef struct packed {
        t_vtx [2:0] vtx;
        logic       odd;
        logic       skip;
    } t_tri;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic               last_segment;
        logic               truncated;
    } t_seg;

    typedef struct packed {
        logic        start;
        logic [63:0] numer;
        logic [31:0] denom;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quot;
        logic [31:0] rem;
    } t_div_rsp;

endpackage

@@ rtl/core/tise_queue.sv @@
// ----------------------------------------------------------------------------
// Two-entry queue
// Decouples producer and consumer; the head is shown while not empty.
// ----------------------------------------------------------------------------
module tise_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         w_wr, w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count missed a push");
    a_pop_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rd && !w_wr) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("queue count missed a pop");
endmodule

@@ rtl/core/tise_front.sv @@
// ----------------------------------------------------------------------------
// Triangle classifier
// Sorts the vertices by value, records the swap parity and flags flat items.
// ----------------------------------------------------------------------------
module tise_front (
    input  tise_pkg::t_vtx i_a,
    input  tise_pkg::t_vtx i_b,
    input  tise_pkg::t_vtx i_c,
    input  logic [30:0]    i_step,
    output tise_pkg::t_tri o_tri
);
    import tise_pkg::*;

    always_comb begin
        t_vtx        w0, w1, w2, wt;
        logic        par;
        logic [32:0] span;
        logic [42:0] scaled;
        w0  = i_a;
        w1  = i_b;
        w2  = i_c;
        wt  = '0;
        par = 1'b0;
        // Two passes of a two-step compare and swap; ties stay put.
        for (int p = 0; p < 2; p++) begin
            if (w0.v > w1.v) begin
                wt = w0; w0 = w1; w1 = wt; par = ~par;
            end
            if (w1.v > w2.v) begin
                wt = w1; w1 = w2; w2 = wt; par = ~par;
            end
        end
        span   = {w2.v[31], w2.v} - {w0.v[31], w0.v};
        scaled = 43'(span) * 43'(SPAN_RATIO);
        o_tri.vtx[0] = w0;
        o_tri.vtx[1] = w1;
        o_tri.vtx[2] = w2;
        o_tri.odd    = par;
        o_tri.skip   = (i_step == 31'd0) || (scaled < 43'(i_step));
    end
endmodule

@@ rtl/core/tise_divider.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division of a 64-bit numerator by a 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module tise_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tise_pkg::t_div_req i_req,
    output tise_pkg::t_div_rsp o_rsp
);
    import tise_pkg::*;

    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem, r_den;
    logic [63:0] r_nq;
    logic [32:0] w_rem2;
    logic        w_ge;

    assign w_rem2 = {r_rem, r_nq[63]};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_nq;
    assign o_rsp.rem  = r_rem;

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: numerator shifts out as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_nq  <= i_req.numer;
            r_den <= i_req.denom;
            r_rem <= 32'd0;
        end else if (r_busy) begin
            r_rem <= w_ge ? 32'(w_rem2 - {1'b0, r_den}) : w_rem2[31:0];
            r_nq  <= {r_nq[62:0], w_ge};
        end
    end
endmodule

@@ rtl/core/tise_back.sv @@
// ----------------------------------------------------------------------------
// Segment sequencer
// Finds the first level, walks the levels and interpolates four endpoints each.
// ----------------------------------------------------------------------------
module tise_back #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  tise_pkg::t_tri     i_tri,
    input  logic [30:0]        i_step,
    input  logic signed [31:0] i_origin,
    output tise_pkg::t_div_req o_div_req,
    input  tise_pkg::t_div_rsp i_div_rsp,
    input  logic               i_out_full,
    output logic               o_out_push,
    output tise_pkg::t_seg     o_seg
);
    import tise_pkg::*;

    localparam int CNT_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LVS   = 3'd1;
    localparam logic [2:0] S_LVW   = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_LSET  = 3'd4;
    localparam logic [2:0] S_LMUL  = 3'd5;
    localparam logic [2:0] S_LWAIT = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]         r_state;
    t_tri               r_tri;
    logic signed [34:0] r_lvl;
    logic [CNT_W-1:0]   r_cnt;
    logic [1:0]         r_j;
    logic [31:0]        r_res [4];
    logic [31:0]        r_pa, r_mag, r_num, r_den;
    logic               r_neg, r_dpos, r_dneg;

    logic signed [34:0] w_v0, w_v1, w_v2, w_nl;
    logic signed [32:0] w_d;
    logic [32:0]        w_dabs;
    t_vtx               w_lo, w_hi;
    logic signed [31:0] w_pa, w_pb;
    logic signed [34:0] w_num;
    logic [32:0]        w_den;
    logic signed [32:0] w_dx;
    logic [32:0]        w_dxabs;
    logic               w_degen;
    logic [31:0]        w_numc;
    logic [32:0]        w_q;
    logic [33:0]        w_res;
    logic               w_more, w_capped, w_last;

    assign w_v0 = {{3{r_tri.vtx[0].v[31]}}, r_tri.vtx[0].v};
    assign w_v1 = {{3{r_tri.vtx[1].v[31]}}, r_tri.vtx[1].v};
    assign w_v2 = {{3{r_tri.vtx[2].v[31]}}, r_tri.vtx[2].v};
    assign w_d    = {r_tri.vtx[0].v[31], r_tri.vtx[0].v} - {i_origin[31], i_origin};
    assign w_dabs = w_d[32] ? 33'(-w_d) : 33'(w_d);
    assign w_nl   = r_lvl + 35'(i_step);

    // Edge selection: short edge first (x then y), then the long edge.
    always_comb begin
        if (r_j[1]) begin
            w_lo = r_tri.vtx[0];
            w_hi = r_tri.vtx[2];
        end else if (r_lvl < w_v1) begin
            w_lo = r_tri.vtx[0];
            w_hi = r_tri.vtx[1];
        end else begin
            w_lo = r_tri.vtx[1];
            w_hi = r_tri.vtx[2];
        end
        w_pa    = r_j[0] ? w_lo.y : w_lo.x;
        w_pb    = r_j[0] ? w_hi.y : w_hi.x;
        w_num   = r_lvl - {{3{w_lo.v[31]}}, w_lo.v};
        w_den   = {w_hi.v[31], w_hi.v} - {w_lo.v[31], w_lo.v};
        w_dx    = {w_pb[31], w_pb} - {w_pa[31], w_pa};
        w_dxabs = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
        w_degen = (w_den == 33'd0) || (w_num <= 35'sd0);
        w_numc  = (w_num > $signed({2'b00, w_den})) ? w_den[31:0] : w_num[31:0];
    end

    // Rounded quotient, half away from zero on the offset.
    assign w_q   = i_div_rsp.quot[32:0]
                 + 33'({i_div_rsp.rem, 1'b0} >= {1'b0, r_den});
    assign w_res = r_neg ? ({r_pa[31], r_pa[31], r_pa} - {1'b0, w_q})
                         : ({r_pa[31], r_pa[31], r_pa} + {1'b0, w_q});

    assign w_more   = (w_nl < w_v2);
    assign w_capped = (r_cnt == CNT_W'(MAX_SEGMENTS - 1));
    assign w_last   = !w_more || w_capped;

    assign o_q_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign o_out_push = (r_state == S_EMIT) && !i_out_full;

    // Divider requests: first-level remainder or one interpolation.
    always_comb begin
        o_div_req.start = 1'b0;
        o_div_req.numer = {31'd0, w_dabs};
        o_div_req.denom = {1'b0, i_step};
        if (r_state == S_LVS) begin
            o_div_req.start = 1'b1;
        end else if (r_state == S_LMUL) begin
            o_div_req.start = 1'b1;
            o_div_req.numer = 64'(r_mag) * 64'(r_num);
            o_div_req.denom = r_den;
        end
    end

    // Endpoint order follows the permutation parity.
    always_comb begin
        if (r_tri.odd) begin
            o_seg.start_x = r_res[0];
            o_seg.start_y = r_res[1];
            o_seg.end_x   = r_res[2];
            o_seg.end_y   = r_res[3];
        end else begin
            o_seg.start_x = r_res[2];
            o_seg.start_y = r_res[3];
            o_seg.end_x   = r_res[0];
            o_seg.end_y   = r_res[1];
        end
        o_seg.last_segment = w_last;
        o_seg.truncated    = w_more && w_capped;
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_j     <= 2'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= i_tri.skip ? S_IDLE : S_LVS;
                    end
                end
                S_LVS: r_state <= S_LVW;
                S_LVW: begin
                    if (i_div_rsp.done) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_cnt   <= '0;
                    r_j     <= 2'd0;
                    r_state <= (r_lvl < w_v2) ? S_LSET : S_IDLE;
                end
                S_LSET: begin
                    if (!w_degen) begin
                        r_state <= S_LMUL;
                    end else if (r_j == 2'd3) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
                S_LMUL: r_state <= S_LWAIT;
                S_LWAIT: begin
                    if (i_div_rsp.done) begin
                        if (r_j == 2'd3) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_LSET;
                        end
                    end
                end
                S_EMIT: begin
                    if (!i_out_full) begin
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + CNT_W'(1);
                            r_j     <= 2'd0;
                            r_state <= S_LSET;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_tri <= i_tri;
        end
        if (r_state == S_LVS) begin
            r_dpos <= !w_d[32] && (w_d != 33'sd0);
            r_dneg <= w_d[32];
        end
        // First level at or above the lowest value.
        if (r_state == S_LVW && i_div_rsp.done) begin
            if (r_dpos && i_div_rsp.rem != 32'd0) begin
                r_lvl <= w_v0 + 35'(i_step) - 35'(i_div_rsp.rem);
            end else if (r_dneg) begin
                r_lvl <= w_v0 + 35'(i_div_rsp.rem);
            end else begin
                r_lvl <= w_v0;
            end
        end
        if (r_state == S_LSET) begin
            r_pa  <= w_pa;
            r_neg <= w_dx[32];
            r_mag <= w_dxabs[31:0];
            r_num <= w_numc;
            r_den <= w_den[31:0];
            if (w_degen) begin
                r_res[r_j] <= w_pa;
            end
        end
        if (r_state == S_LWAIT && i_div_rsp.done) begin
            r_res[r_j] <= w_res[31:0];
        end
        if (o_out_push && !w_last) begin
            r_lvl <= w_nl;
        end
    end

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_req.start |-> !i_div_rsp.busy) else $error("divider restarted while busy");
    a_emit_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_lvl < w_v2)) else $error("level outside span");
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_push && w_capped) |-> o_seg.last_segment)
        else $error("segment cap passed");
endmodule

@@ rtl/core/triangle_isoline_segments_core.sv @@
// ----------------------------------------------------------------------------
// Triangle isoline segments core
// Marching-triangles contour segments for one triangle per item.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// input     in         push / full            i_a_* i_b_* i_c_* (x, y, value)
// result    out        empty / pop            o_start_*, o_end_*, flags
// config    in         i_cfg_valid / ready    i_cfg_index, i_cfg_data
//
// Each level interpolates four endpoints, each one that is not degenerate on the
// one-bit-a-cycle divider; the first level is also found with a division.
// Reset is synchronous and active low; it restores the default step and origin.
// A full result queue stalls the sequencer; a two-item queue keeps input open.
// ----------------------------------------------------------------------------
module triangle_isoline_segments_core #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_value,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_value,
    input  logic signed [31:0] i_c_x,
    input  logic signed [31:0] i_c_y,
    input  logic signed [31:0] i_c_value,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_start_x,
    output logic signed [31:0] o_start_y,
    output logic signed [31:0] o_end_x,
    output logic signed [31:0] o_end_y,
    output logic               o_last_segment,
    output logic               o_truncated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import tise_pkg::*;

    logic [30:0]        r_step;
    logic signed [31:0] r_origin;
    t_vtx               w_a, w_b, w_c;
    t_tri               w_tri_in, w_tri_q;
    logic               w_q_empty, w_q_pop;
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;
    logic               w_out_full, w_out_push;
    t_seg               w_seg_in, w_seg_q;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= 31'd13107;
            r_origin <= 32'sd0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_STEP) begin
                r_step <= i_cfg_data[30:0];
            end else if (i_cfg_index == REG_ORIGIN) begin
                r_origin <= i_cfg_data;
            end
        end
    end

    assign w_a = '{x: i_a_x, y: i_a_y, v: i_a_value};
    assign w_b = '{x: i_b_x, y: i_b_y, v: i_b_value};
    assign w_c = '{x: i_c_x, y: i_c_y, v: i_c_value};

    // Front: sort and classify, then queue the item.
    tise_front u_front (
        .i_a    (w_a),
        .i_b    (w_b),
        .i_c    (w_c),
        .i_step (r_step),
        .o_tri  (w_tri_in)
    );

    tise_queue #(.W($bits(t_tri))) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_tri_in),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_data  (w_tri_q),
        .o_empty (w_q_empty)
    );

    // Back: level walk and interpolation.
    tise_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    tise_back #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .o_q_pop    (w_q_pop),
        .i_tri      (w_tri_q),
        .i_step     (r_step),
        .i_origin   (r_origin),
        .o_div_req  (w_div_req),
        .i_div_rsp  (w_div_rsp),
        .i_out_full (w_out_full),
        .o_out_push (w_out_push),
        .o_seg      (w_seg_in)
    );

    tise_queue #(.W($bits(t_seg))) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_seg_in),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_seg_q),
        .o_empty (empty)
    );

    assign o_start_x      = w_seg_q.start_x;
    assign o_start_y      = w_seg_q.start_y;
    assign o_end_x        = w_seg_q.end_x;
    assign o_end_y        = w_seg_q.end_y;
    assign o_last_segment = w_seg_q.last_segment;
    assign o_truncated    = w_seg_q.truncated;
endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle isoline segments core testbench
// Sends triangles through the input queue, predicts the contour segments of
// each one and checks every segment that leaves the result queue, field by
// field, under several step and origin settings, with random idling on both
// sides and one long stall of the result side.
// ----------------------------------------------------------------------------
module testbench;
    import tise_pkg::*;

    localparam int             SEG_CAP    = 64;
    localparam longint         CYCLE_CAP  = 40000000;
    localparam int             SETTLE     = 400;
    localparam logic [31:0]    MAX_I      = 32'h7FFF_FFFF;
    localparam logic [31:0]    MIN_I      = 32'h8000_0000;

    // Predictor of the segments of one triangle, and the store of those
    // still to come out of the block.
    class seg_scoreboard;
        longint step_q;
        longint origin_q;
        t_seg   pending_segs[$];
        int     errors;

        function new();
            step_q   = 13107;
            origin_q = 0;
            errors   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            if (idx == REG_STEP) begin
                step_q = longint'(data[30:0]);
            end else if (idx == REG_ORIGIN) begin
                origin_q = longint'($signed(data));
            end
        endfunction

        function int pending();
            return pending_segs.size();
        endfunction

        // Point on edge p->q at a given fraction, rounded half away from p.
        function longint interpolate(longint p, longint q, longint num, longint den);
            longint            dx;
            longint unsigned   mag;
            longint unsigned   prod;
            longint unsigned   quo;
            longint unsigned   rem;
            dx = q - p;
            if (den <= 0 || num <= 0) begin
                return p;
            end
            if (num > den) begin
                num = den;
            end
            mag  = (dx < 0) ? longint'(-dx) : longint'(dx);
            prod = mag * longint'(num);
            quo  = prod / longint'(den);
            rem  = prod % longint'(den);
            if (2 * rem >= longint'(den)) begin
                quo++;
            end
            return (dx < 0) ? p - longint'(quo) : p + longint'(quo);
        endfunction

        function void note_triangle(t_vtx a, t_vtx b, t_vtx c);
            longint px[3];
            longint py[3];
            longint pv[3];
            int     ord[3];
            int     swaps;
            int     t;
            int     n;
            int     la;
            int     lb;
            longint v0;
            longint v1;
            longint v2;
            longint d;
            longint k;
            longint lvl;
            longint lx;
            longint ly;
            longint rx;
            longint ry;
            t_seg   s;
            px[0] = a.x; py[0] = a.y; pv[0] = a.v;
            px[1] = b.x; py[1] = b.y; pv[1] = b.v;
            px[2] = c.x; py[2] = c.y; pv[2] = c.v;
            ord[0] = 0; ord[1] = 1; ord[2] = 2;
            swaps = 0;
            n     = 0;
            // Two bubble passes; ties never swap.
            for (int pass = 0; pass < 2; pass++) begin
                if (pv[ord[0]] > pv[ord[1]]) begin
                    t = ord[0]; ord[0] = ord[1]; ord[1] = t; swaps++;
                end
                if (pv[ord[1]] > pv[ord[2]]) begin
                    t = ord[1]; ord[1] = ord[2]; ord[2] = t; swaps++;
                end
            end
            v0 = pv[ord[0]];
            v1 = pv[ord[1]];
            v2 = pv[ord[2]];
            if (step_q == 0) begin
                return;
            end
            if ((v2 - v0) * 1000 < step_q) begin
                return;
            end
            // First level at or above the lowest value.
            d = v0 - origin_q;
            k = d / step_q;
            if (d % step_q != 0 && d > 0) begin
                k++;
            end
            lvl = k * step_q + origin_q;
            while (lvl < v2 && n < SEG_CAP) begin
                if (lvl < v1) begin
                    la = ord[0]; lb = ord[1];
                end else begin
                    la = ord[1]; lb = ord[2];
                end
                lx = interpolate(px[la], px[lb], lvl - pv[la], pv[lb] - pv[la]);
                ly = interpolate(py[la], py[lb], lvl - pv[la], pv[lb] - pv[la]);
                rx = interpolate(px[ord[0]], px[ord[2]], lvl - v0, v2 - v0);
                ry = interpolate(py[ord[0]], py[ord[2]], lvl - v0, v2 - v0);
                if (swaps % 2 == 1) begin
                    s.start_x = 32'(lx); s.start_y = 32'(ly);
                    s.end_x   = 32'(rx); s.end_y   = 32'(ry);
                end else begin
                    s.start_x = 32'(rx); s.start_y = 32'(ry);
                    s.end_x   = 32'(lx); s.end_y   = 32'(ly);
                end
                s.last_segment = 1'b0;
                s.truncated    = 1'b0;
                pending_segs.insert(pending_segs.size(), s);
                n++;
                lvl += step_q;
            end
            if (n > 0) begin
                s = pending_segs.pop_back();
                s.last_segment = 1'b1;
                s.truncated    = (lvl < v2);
                pending_segs.insert(pending_segs.size(), s);
            end
        endfunction

        task report(string what, longint got, longint want);
            $display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_segment(t_seg got);
            t_seg want;
            if (pending_segs.size() == 0) begin
                report("unexpected segment", 1, 0);
                return;
            end
            want = pending_segs.pop_front();
            if (got.start_x !== want.start_x) report("start_x", got.start_x, want.start_x);
            if (got.start_y !== want.start_y) report("start_y", got.start_y, want.start_y);
            if (got.end_x !== want.end_x) report("end_x", got.end_x, want.end_x);
            if (got.end_y !== want.end_y) report("end_y", got.end_y, want.end_y);
            if (got.last_segment !== want.last_segment)
                report("last_segment", got.last_segment, want.last_segment);
            if (got.truncated !== want.truncated)
                report("truncated", got.truncated, want.truncated);
        endtask
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               push        = 1'b0;
    logic               full;
    logic signed [31:0] i_a_x       = '0;
    logic signed [31:0] i_a_y       = '0;
    logic signed [31:0] i_a_value   = '0;
    logic signed [31:0] i_b_x       = '0;
    logic signed [31:0] i_b_y       = '0;
    logic signed [31:0] i_b_value   = '0;
    logic signed [31:0] i_c_x       = '0;
    logic signed [31:0] i_c_y       = '0;
    logic signed [31:0] i_c_value   = '0;
    logic               empty;
    logic               pop         = 1'b0;
    logic signed [31:0] o_start_x;
    logic signed [31:0] o_start_y;
    logic signed [31:0] o_end_x;
    logic signed [31:0] o_end_y;
    logic               o_last_segment;
    logic               o_truncated;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data  = '0;

    seg_scoreboard sb = new();
    longint        cur_step  = 13107;
    bit            quiet     = 1'b0;
    int            hold_len  = 0;
    longint        cycles    = 0;

    triangle_isoline_segments_core u_top (.*);

    // Clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: check each accepted segment, then decide the next pop.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_segment('{o_start_x, o_start_y, o_end_x, o_end_y,
                               o_last_segment, o_truncated});
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_len > 0) begin
            hold_len--;
            pop <= 1'b0;
        end else if (quiet) begin
            pop <= 1'b1;
        end else begin
            pop <= ($urandom_range(99) >= 16);
        end
    end

    function automatic t_vtx vtx(logic [31:0] x, logic [31:0] y, logic [31:0] v);
        t_vtx p;
        p.x = x; p.y = y; p.v = v;
        return p;
    endfunction

    // Offer one triangle and wait until the block takes it.
    task automatic send(t_vtx a, t_vtx b, t_vtx c);
        push      <= 1'b1;
        i_a_x     <= a.x; i_a_y <= a.y; i_a_value <= a.v;
        i_b_x     <= b.x; i_b_y <= b.y; i_b_value <= b.v;
        i_c_x     <= c.x; i_c_y <= c.y; i_c_value <= c.v;
        do @(posedge i_clk); while (full);
        sb.note_triangle(a, b, c);
        if (!quiet && $urandom_range(99) < 16) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // One register write; valid drops and the channel rests before the next one.
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_reg(idx, data);
        if (idx == REG_STEP) begin
            cur_step = longint'(data[30:0]);
        end
        @(posedge i_clk);
    endtask

    // Wait for every expected segment, then let triangles without output finish.
    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Random triangle: mostly a span of a chosen number of levels, with some
    // flat or fully random noise.
    task automatic send_random();
        longint          span;
        longint          lo;
        longint          vals[3];
        longint          t;
        int              r;
        int              j;
        int              levels;
        longint unsigned wide;
        r = $urandom_range(99);
        if (r < 12) begin
            span = (cur_step - 1) / 1000;
            span = longint'($urandom) % (span + 1);
        end else begin
            if (r < 15) levels = $urandom_range(64, 72);
            else if (r < 28) levels = 0;
            else levels = $urandom_range(1, 5);
            span = levels * cur_step + (longint'($urandom) % cur_step);
        end
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        lo = longint'($signed($urandom));
        if (lo + span > 2147483647) lo = 2147483647 - span;
        vals[0] = lo;
        vals[1] = lo + span;
        case ($urandom_range(9))
            0: vals[2] = lo;
            1: vals[2] = lo + span;
            default: begin
                wide    = {$urandom, $urandom};
                vals[2] = lo + longint'(wide % longint'(span + 1));
            end
        endcase
        if (r < 6 && cur_step >= (longint'(1) << 28)) begin
            for (j = 0; j < 3; j++) vals[j] = longint'($signed($urandom));
        end
        for (j = 2; j > 0; j--) begin
            r = $urandom_range(j);
            t = vals[j]; vals[j] = vals[r]; vals[r] = t;
        end
        send(vtx($urandom, $urandom, 32'(vals[0])),
             vtx($urandom, $urandom, 32'(vals[1])),
             vtx($urandom, $urandom, 32'(vals[2])));
    endtask

    task automatic send_randoms(int count);
        repeat (count) send_random();
    endtask

    // Stimulus sequence.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default step 0.2 and origin zero.
        send(vtx(MAX_I, MIN_I, 0), vtx(MIN_I, MAX_I, 40000), vtx(0, -1, 20000));
        send(vtx(1, 2, 40000), vtx(3, 4, 0), vtx(5, 6, 20000));
        send(vtx(10, 20, 26214), vtx(-30, 40, 0), vtx(50, -60, 13107));
        send(vtx(7, 8, 5000), vtx(9, 10, 5000), vtx(11, 12, 5000));
        send(vtx(0, 0, 0), vtx(65536, 0, 13), vtx(0, 65536, 7));
        send(vtx(0, 0, 0), vtx(65536, 0, 14), vtx(0, 65536, 3));
        send(vtx(100, 200, 1), vtx(300, 400, 13106), vtx(500, 600, 500));
        send(vtx(0, 0, 0), vtx(1000, 0, 0), vtx(0, 1000, 30000));
        send(vtx(0, 0, 30000), vtx(1000, 0, 30000), vtx(0, 1000, 0));
        send(vtx(-5, 5, 0), vtx(MAX_I, 3, 64 * 13107), vtx(9, MIN_I, 100));
        send(vtx(-5, 5, 0), vtx(MAX_I, 3, 65 * 13107), vtx(9, MIN_I, 100));
        send(vtx(MIN_I, MIN_I, MIN_I), vtx(MAX_I, MAX_I, MAX_I), vtx(0, 0, 0));
        send(vtx(123, 456, -50000), vtx(-789, 12, -10000), vtx(345, -678, -30000));
        drain();

        // Zero step traces nothing.
        write_reg(REG_STEP, 32'd0);
        send(vtx(1, 2, 0), vtx(3, 4, 100000), vtx(5, 6, 50000));
        send(vtx(MIN_I, 0, MIN_I), vtx(MAX_I, 0, MAX_I), vtx(0, 0, 0));
        drain();

        // Smallest step, lowest origin.
        write_reg(REG_STEP, 32'd1);
        write_reg(REG_ORIGIN, MIN_I);
        send(vtx(0, 0, 0), vtx(65536, 65536, 3), vtx(-65536, 65536, 1));
        send(vtx(MAX_I, 1, MAX_I - 2), vtx(2, MAX_I, MAX_I), vtx(MIN_I, 3, MAX_I - 1));
        send(vtx(4, 4, MIN_I), vtx(8, 8, MIN_I + 2), vtx(6, 6, MIN_I + 1));
        send_randoms(60);
        drain();

        // Largest step (top bit dropped by the register), highest origin.
        write_reg(REG_STEP, 32'hFFFF_FFFF);
        write_reg(REG_ORIGIN, MAX_I);
        send(vtx(MAX_I, MIN_I, MIN_I), vtx(MIN_I, MAX_I, MAX_I), vtx(0, 0, 0));
        send(vtx(1, 1, -1), vtx(2, 2, MAX_I), vtx(3, 3, MIN_I));
        send_randoms(60);
        drain();

        // Defaults again, with no idling on either side.
        write_reg(REG_STEP, 32'd13107);
        write_reg(REG_ORIGIN, 32'd0);
        quiet = 1'b1;
        send_randoms(60);
        quiet = 1'b0;

        // Long stall of the result side while triangles keep coming.
        hold_len = 6000;
        send_randoms(80);
        drain();

        write_reg(REG_STEP, $urandom_range(1000, 1 << 20));
        write_reg(REG_ORIGIN, $urandom);
        send_randoms(100);
        drain();

        write_reg(REG_STEP, (32'd1 << 28) + $urandom_range(0, 1 << 20));
        write_reg(REG_ORIGIN, $urandom);
        send_randoms(100);
        drain();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

@@ triangle_isoline_segments_core.f @@
rtl/core/tise_pkg.sv
rtl/core/tise_queue.sv
rtl/core/tise_front.sv
rtl/core/tise_divider.sv
rtl/core/tise_back.sv
rtl/core/triangle_isoline_segments_core.sv
test/testbench.sv
